// ===== rtl/lsa_pkg.sv =====
//------------------------------------------------------------------------------
// lsa_pkg
// Shared types and codes of the layer slot allocator.
//------------------------------------------------------------------------------
package lsa_pkg;

	localparam int DEF_MAX_SLOTS   = 128;
	localparam int DEF_HANDLE_BITS = 32;
	localparam int DEF_ACTIVE      = 128;

	localparam logic [2:0] OP_ALLOC  = 3'd0;
	localparam logic [2:0] OP_FREE   = 3'd1;
	localparam logic [2:0] OP_TOUCH  = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_EVICT  = 3'd4;
	localparam logic [2:0] OP_FRAME  = 3'd5;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NOTFOUND = 2'd1;
	localparam logic [1:0] STS_FULL     = 2'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] handle;
		logic [63:0] frame_number;
		logic [7:0]  evict_count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [6:0]  slot_index;
		logic [7:0]  evicted;
		logic [7:0]  used_count;
	} result_t;

	typedef struct packed {
		logic rebuild;
		logic pop;
		logic push;
	} fs_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_SCAN_RD,
		S_SCAN_EV,
		S_DONE
	} state_t;

endpackage

// ===== rtl/lsa_slot_mem.sv =====
//------------------------------------------------------------------------------
// lsa_slot_mem
// Per-slot handle and frame stamp memories, one write and one read port each.
//------------------------------------------------------------------------------
module lsa_slot_mem #(
	parameter int MAX_SLOTS   = 128,
	parameter int HANDLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          we_h,
	input  logic                          we_f,
	input  logic [$clog2(MAX_SLOTS)-1:0]  waddr,
	input  logic [HANDLE_BITS-1:0]        hwdata,
	input  logic [63:0]                   fwdata,
	input  logic [$clog2(MAX_SLOTS)-1:0]  raddr,
	output logic [HANDLE_BITS-1:0]        hrdata,
	output logic [63:0]                   frdata
);
	logic [HANDLE_BITS-1:0] hmem [MAX_SLOTS];
	logic [63:0]            fmem [MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (we_h) begin
			hmem[waddr] <= hwdata;
		end
		hrdata <= hmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_f) begin
			fmem[waddr] <= fwdata;
		end
		frdata <= fmem[raddr];
	end

endmodule

// ===== rtl/lsa_free_stack.sv =====
//------------------------------------------------------------------------------
// lsa_free_stack
// LIFO of free slots. A low-water mark stands in for the rebuild fill:
// positions below it were never written and read as n-1-position.
//------------------------------------------------------------------------------
module lsa_free_stack #(
	parameter int MAX_SLOTS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsa_pkg::fs_ctl_t                ctl,
	input  logic [$clog2(MAX_SLOTS)-1:0]    push_slot,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]  n_slots,
	input  logic [$clog2(MAX_SLOTS+1)-1:0]  rebuild_n,
	output logic [$clog2(MAX_SLOTS+1)-1:0]  top,
	output logic [$clog2(MAX_SLOTS)-1:0]    pop_slot
);
	import lsa_pkg::*;

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int RST_N  = (DEF_ACTIVE > MAX_SLOTS) ? MAX_SLOTS : DEF_ACTIVE;

	logic [SLOT_W-1:0] mem [MAX_SLOTS];
	logic [CNT_W-1:0]  top_q;
	logic [CNT_W-1:0]  lw_q;
	logic [CNT_W-1:0]  ptr;
	logic [SLOT_W-1:0] rd_q;
	logic [SLOT_W-1:0] alt_q;
	logic              wr_q;

	assign ptr = top_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= CNT_W'(RST_N);
			lw_q  <= CNT_W'(RST_N);
		end else if (ctl.rebuild) begin
			top_q <= rebuild_n;
			lw_q  <= rebuild_n;
		end else if (ctl.pop) begin
			top_q <= ptr;
			if (ptr < lw_q) begin
				lw_q <= ptr;
			end
		end else if (ctl.push) begin
			top_q <= top_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[top_q[SLOT_W-1:0]] <= push_slot;
		end
		if (ctl.pop) begin
			rd_q  <= mem[ptr[SLOT_W-1:0]];
			alt_q <= SLOT_W'(n_slots - top_q);
			wr_q  <= (ptr >= lw_q);
		end
	end

	assign top      = top_q;
	assign pop_slot = wr_q ? rd_q : alt_q;

endmodule

// ===== rtl/layer_slot_allocator_lru.sv =====
//------------------------------------------------------------------------------
// layer_slot_allocator_lru
// Slot pool with LIFO free list, handle search and oldest-first eviction.
//------------------------------------------------------------------------------
// One item at a time; busy stays high through the result strobe. Results are
// shown on done for one cycle and cannot be stalled. Allocate pops a free slot
// and writes it; begin frame and unused opcodes go straight to done; a handle
// search compares each active slot in turn until a hit; evict makes one pass
// over the active slots per slot freed, and one more empty pass when it runs
// out of used slots; a single shared compare walks the slot memories, one read
// per slot. A configuration write rebuilds the pool at once, no clearing pass.
//------------------------------------------------------------------------------
module layer_slot_allocator_lru #(
	parameter int MAX_SLOTS   = lsa_pkg::DEF_MAX_SLOTS,
	parameter int HANDLE_BITS = lsa_pkg::DEF_HANDLE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lsa_pkg::cmd_t    cmd,
	output logic             done,
	output lsa_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);
	import lsa_pkg::*;

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int HW     = HANDLE_BITS + 32;
	localparam int RST_N  = (DEF_ACTIVE > MAX_SLOTS) ? MAX_SLOTS : DEF_ACTIVE;

	state_t                 state_q, state_d;
	cmd_t                   cmd_q;
	logic [CNT_W-1:0]       n_q, cfg_n, top;
	logic [CNT_W-1:0]       idx_q;
	logic [SLOT_W-1:0]      idx_s, best_q, cand, pop_slot, clr_addr, waddr;
	logic                   best_vld_q, cand_vld, older, h_hit, last;
	logic [63:0]            best_frame_q, frame_q, f_rd;
	logic [7:0]             evicted_q;
	logic [1:0]             status_q;
	logic [31:0]            hout_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [MAX_SLOTS-1:0]   in_use_q;
	logic [HANDLE_BITS-1:0] counter_q, cnt_inc, h_rd;
	logic                   accept, cfg_wr, set_use, clr_use, we_h, we_f;
	fs_ctl_t                fs;

	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		if (cfg_data == 8'd0) begin
			cfg_n = CNT_W'(1);
		end else if (32'(cfg_data) > MAX_SLOTS) begin
			cfg_n = CNT_W'(MAX_SLOTS);
		end else begin
			cfg_n = CNT_W'(cfg_data);
		end
	end

	assign idx_s    = idx_q[SLOT_W-1:0];
	assign last     = ((idx_q + CNT_W'(1)) == n_q);
	assign h_hit    = in_use_q[idx_s] && (HW'(h_rd) == HW'(cmd_q.handle));
	assign older    = in_use_q[idx_s] && (!best_vld_q || f_rd < best_frame_q);
	assign cand_vld = best_vld_q || older;
	assign cand     = older ? idx_s : best_q;
	assign cnt_inc  = counter_q + HANDLE_BITS'(1);

	lsa_slot_mem #(
		.MAX_SLOTS  (MAX_SLOTS),
		.HANDLE_BITS(HANDLE_BITS)
	) u_mem (
		.clk   (clk),
		.we_h  (we_h),
		.we_f  (we_f),
		.waddr (waddr),
		.hwdata(counter_q),
		.fwdata(frame_q),
		.raddr (idx_s),
		.hrdata(h_rd),
		.frdata(f_rd)
	);

	lsa_free_stack #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fs),
		.push_slot(clr_addr),
		.n_slots  (n_q),
		.rebuild_n(cfg_n),
		.top      (top),
		.pop_slot (pop_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fs         = '0;
		fs.rebuild = cfg_wr;
		we_h       = 1'b0;
		we_f       = 1'b0;
		waddr      = idx_s;
		set_use    = 1'b0;
		clr_use    = 1'b0;
		clr_addr   = idx_s;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DONE;
					case (cmd.opcode)
						OP_ALLOC: begin
							if (top != '0) begin
								fs.pop  = 1'b1;
								state_d = S_ALLOC;
							end
						end
						OP_FREE, OP_TOUCH, OP_LOOKUP: begin
							if (cmd.handle != 32'd0) begin
								state_d = S_SCAN_RD;
							end
						end
						OP_EVICT: begin
							if (cmd.evict_count != 8'd0) begin
								state_d = S_SCAN_RD;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_ALLOC: begin
				we_h    = 1'b1;
				we_f    = 1'b1;
				waddr   = pop_slot;
				set_use = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				if (cmd_q.opcode == OP_EVICT) begin
					state_d = S_SCAN_RD;
					if (last) begin
						if (cand_vld) begin
							clr_use  = 1'b1;
							clr_addr = cand;
							fs.push  = 1'b1;
							if ((evicted_q + 8'd1) == cmd_q.evict_count) begin
								state_d = S_DONE;
							end
						end else begin
							state_d = S_DONE;
						end
					end
				end else if (h_hit) begin
					state_d = S_DONE;
					if (cmd_q.opcode == OP_FREE) begin
						clr_use = 1'b1;
						fs.push = 1'b1;
					end else if (cmd_q.opcode == OP_TOUCH) begin
						we_f = 1'b1;
					end
				end else begin
					state_d = last ? S_DONE : S_SCAN_RD;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= CNT_W'(RST_N);
			in_use_q   <= '0;
			counter_q  <= HANDLE_BITS'(1);
			frame_q    <= '0;
			idx_q      <= '0;
			best_vld_q <= 1'b0;
			evicted_q  <= '0;
		end else begin
			if (cfg_wr) begin
				n_q       <= cfg_n;
				in_use_q  <= '0;
				counter_q <= HANDLE_BITS'(1);
			end
			if (set_use) begin
				in_use_q[pop_slot] <= 1'b1;
				counter_q <= (cnt_inc == '0) ? HANDLE_BITS'(1) : cnt_inc;
			end
			if (clr_use) begin
				in_use_q[clr_addr] <= 1'b0;
			end
			if (accept) begin
				idx_q      <= '0;
				best_vld_q <= 1'b0;
				evicted_q  <= '0;
				if (cmd.opcode == OP_FRAME) begin
					frame_q <= cmd.frame_number;
				end
			end
			if (state_q == S_SCAN_EV) begin
				if (cmd_q.opcode == OP_EVICT && last) begin
					idx_q      <= '0;
					best_vld_q <= 1'b0;
					if (cand_vld) begin
						evicted_q <= evicted_q + 8'd1;
					end
				end else begin
					idx_q      <= idx_q + CNT_W'(1);
					best_vld_q <= cand_vld;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			hout_q   <= '0;
			slot_q   <= '0;
			if (cmd.opcode == OP_ALLOC && top == '0) begin
				status_q <= STS_FULL;
			end else if ((cmd.opcode == OP_FREE || cmd.opcode == OP_TOUCH ||
			     cmd.opcode == OP_LOOKUP) && cmd.handle == 32'd0) begin
				status_q <= STS_NOTFOUND;
			end else begin
				status_q <= STS_OK;
			end
		end
		if (state_q == S_ALLOC) begin
			hout_q <= 32'(counter_q);
			slot_q <= pop_slot;
		end
		if (state_q == S_SCAN_EV) begin
			if (cmd_q.opcode == OP_EVICT) begin
				best_q       <= cand;
				best_frame_q <= older ? f_rd : best_frame_q;
			end else if (h_hit) begin
				slot_q <= idx_s;
			end else if (last) begin
				status_q <= STS_NOTFOUND;
			end
		end
	end

	assign done              = (state_q == S_DONE);
	assign result.status     = status_q;
	assign result.handle_out = hout_q;
	assign result.slot_index = 7'(slot_q);
	assign result.evicted    = evicted_q;
	assign result.used_count = 8'(n_q - top);

endmodule

// ===== rtl/lsa_checker.sv =====
//------------------------------------------------------------------------------
// lsa_checker
// Port-level checks of the allocator's command and result timing.
//------------------------------------------------------------------------------
module lsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input lsa_pkg::result_t result,
	input logic             cfg_ready
);
	import lsa_pkg::*;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item taken without busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result outside busy");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("result strobe repeated");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == STS_OK || result.status == STS_NOTFOUND ||
		          result.status == STS_FULL)) else $error("bad status");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !busy) else $error("config ready while busy");

endmodule

bind layer_slot_allocator_lru lsa_checker u_lsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.result   (result),
	.cfg_ready(cfg_ready)
);
